// File: sv/tcrr_pkg.sv
`default_nettype none

package tcrr_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int ACT_W     = 2;
  localparam int IN_DATA_W = 16;   // channel, rx_byte
  localparam int IN_USER_W = 1;    // req_type
  localparam int OUT_DATA_W = 8;   // read_data
  localparam int OUT_USER_W = 2;   // read_valid, dropped

  // Request kinds carried on in_tuser
  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_READ = 1'b1;

endpackage

`default_nettype wire

// File: sv/tcrr_ram.sv
`default_nettype none

module tcrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/tagged_channel_receive_rings.sv
`default_nettype none

// Channel  | Dir | Signals                       | Contents
// ---------+-----+-------------------------------+------------------------------------
// in       | in  | in_tvalid/in_tready           | tdata: channel, rx_byte; tuser: req_type
// out      | out | out_tvalid/out_tready         | tdata: read_data; tuser: read_valid, dropped
// cfg      | in  | cfg_wr_en/cfg_wr_data         | active_channels
//
// A receive beat or a read of an empty ring reaches the output register in the cycle
// after it is taken; a read that pops a byte passes the registered ring RAM read first.
// One beat is in flight at a time; a new beat is taken in the cycle the
// previous result leaves the output register (or once it is empty).
// Synchronous active-low reset clears pointers, active_channels and control,
// not the ring RAM. out_tready low holds the result and stalls the input side.
module tagged_channel_receive_rings
  import tcrr_pkg::*;
#(
  parameter int CHANNELS   = 4,
  parameter int RING_DEPTH = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] channel, [15:8] rx_byte
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // [0] req_type
  // result stream
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] read_data
  output      logic [OUT_USER_W-1:0] out_tuser,  // [0] read_valid, [1] dropped
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [ACT_W-1:0]      cfg_wr_data
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int MEM_D  = CHANNELS * RING_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t state_r;

  logic [ACT_W-1:0]  active_r;
  logic [PTR_W-1:0]  wptr_r [CHANNELS];
  logic [PTR_W-1:0]  rptr_r [CHANNELS];

  logic              out_tvalid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_rvalid_r;
  logic              out_drop_r;

  // Input beat fields
  logic              req_kind;
  logic [BYTE_W-1:0] ch_tag;
  logic [BYTE_W-1:0] rx_byte;
  assign req_kind = in_tuser[0];
  assign ch_tag   = in_tdata[BYTE_W-1:0];
  assign rx_byte  = in_tdata[2*BYTE_W-1:BYTE_W];

  logic              in_acc;
  logic              ch_active;
  logic [CH_W-1:0]   sel_ch;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic              ring_empty;
  logic [PTR_W-1:0]  sel_ptr;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // Channel decode: active tags index directly, unknown read tags use channel 0
  always_comb begin
    ch_active = ({{(BYTE_W - ACT_W){1'b0}}, active_r} >= ch_tag) &&
                ({1'b0, ch_tag} < (BYTE_W + 1)'(CHANNELS));
    sel_ch    = ch_active ? ch_tag[CH_W-1:0] : '0;
    wp        = wptr_r[sel_ch];
    rp        = rptr_r[sel_ch];
    ring_empty = (wp == rp);
    sel_ptr   = (req_kind == REQ_RX) ? wp : rp;
    ram_addr  = ADDR_W'(sel_ch) * ADDR_W'(RING_DEPTH) + ADDR_W'(sel_ptr);
    ram_we    = in_acc && (req_kind == REQ_RX) && ch_active;
    ram_re    = in_acc && (req_kind == REQ_READ) && !ring_empty;
  end

  tcrr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_D)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (rx_byte),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Pointer advance with wrap at ring depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Configuration and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        wptr_r[i] <= '0;
        rptr_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      if (ram_we) begin
        wptr_r[sel_ch] <= ptr_inc(wp);
      end
      if (ram_re) begin
        rptr_r[sel_ch] <= ptr_inc(rp);
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && !ram_re) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= '0;
            out_rvalid_r <= 1'b0;
            out_drop_r   <= (req_kind == REQ_RX) && !ch_active;
          end else if (out_tvalid_r && out_tready) begin
            out_tvalid_r <= 1'b0;
          end
          if (ram_re) begin
            state_r <= S_POP;
          end
        end
        S_POP: begin
          // RAM data is ready; output register was emptied on entry
          out_tvalid_r <= 1'b1;
          out_data_r   <= ram_rdata;
          out_rvalid_r <= 1'b1;
          out_drop_r   <= 1'b0;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_drop_r, out_rvalid_r};

endmodule

`default_nettype wire

// File: sim/tagged_channel_receive_rings_test.sv
`default_nettype none

module tagged_channel_receive_rings_test;
  import tcrr_pkg::*;

  localparam int CHANNELS   = 4;
  localparam int RING_DEPTH = 128;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  typedef struct packed {
    logic             kind;
    logic [BYTE_W-1:0] chan;
    logic [BYTE_W-1:0] data;
  } ring_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_data;
    logic              rd_ok;
    logic              drop;
  } ring_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [7:0] channel, [15:8] rx_byte
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [0] req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [7:0] read_data
  logic [OUT_USER_W-1:0] out_tuser;       // [0] read_valid, [1] dropped
  logic                  cfg_wr_en = 1'b0;
  logic [ACT_W-1:0]      cfg_wr_data = '0;

  // stimulus bookkeeping
  ring_req_t    pending[$];
  ring_result_t ring_expect[$];
  int           items_issued = 0;
  int           items_accepted = 0;
  int           out_beats = 0;
  int           errors = 0;
  logic         in_beat_seen = 1'b0;

  // predictor state
  logic [BYTE_W-1:0] ring_mem [CHANNELS][RING_DEPTH];
  logic [PTR_W-1:0]  wr_ptr [CHANNELS];
  logic [PTR_W-1:0]  rd_ptr [CHANNELS];
  logic [ACT_W-1:0]  act_ch = '0;

  tagged_channel_receive_rings #(
    .CHANNELS   (CHANNELS),
    .RING_DEPTH (RING_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic chan_active(logic [BYTE_W-1:0] chan);
    return (chan <= act_ch) && (chan < CHANNELS);
  endfunction

  // Apply one request to the predicted rings and return its result
  function automatic ring_result_t serve_request(ring_req_t r);
    ring_result_t res;
    int           c;
    res = '0;
    if (r.kind == REQ_RX) begin
      if (!chan_active(r.chan)) begin
        res.drop = 1'b1;
      end else begin
        c = int'(r.chan);
        ring_mem[c][wr_ptr[c]] = r.data;
        wr_ptr[c] = next_ptr(wr_ptr[c]);
      end
    end else begin
      c = chan_active(r.chan) ? int'(r.chan) : 0;
      if (wr_ptr[c] != rd_ptr[c]) begin
        res.rd_data = ring_mem[c][rd_ptr[c]];
        res.rd_ok   = 1'b1;
        rd_ptr[c]   = next_ptr(rd_ptr[c]);
      end
    end
    return res;
  endfunction

  // Sender: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    ring_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_beat_seen) begin
      // hold the offered beat until taken
    end else if (gap_left > 0) begin
      gap_left  <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (pending.size() > 0) begin
      nxt = pending.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= {nxt.data, nxt.chan};
      in_tuser  <= nxt.kind;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: stall pattern switching between modes, plus one long hold-off
  ready_mode_t rx_mode = READY_ALWAYS;
  int          mode_left = 50;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;
  logic [1:0]  rx_cycle = '0;

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && out_beats >= 400) begin
      long_hold_done <= 1'b1;
      hold_left      <= 600;
      out_tready     <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= ready_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_HALF:   out_tready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
        default:      out_tready <= (rx_cycle != 2'd0);
      endcase
    end
  end

  // Monitor: predict on every accepted input beat, check every result beat
  always @(posedge clk) begin
    ring_req_t    seen;
    ring_result_t want;
    if (!rst_n) begin
      in_beat_seen <= 1'b0;
      act_ch = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        wr_ptr[c] = '0;
        rd_ptr[c] = '0;
      end
    end else begin
      in_beat_seen <= in_tvalid && in_tready;
      if (cfg_wr_en)
        act_ch = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        seen.kind = in_tuser[0];
        seen.chan = in_tdata[7:0];
        seen.data = in_tdata[15:8];
        ring_expect.push_back(serve_request(seen));
        items_accepted++;
      end
      if (out_tvalid && out_tready) begin
        out_beats++;
        if (ring_expect.size() == 0) begin
          $display("%0t: result beat with nothing expected: data %02h user %b",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = ring_expect.pop_front();
          if (out_tdata[7:0] !== want.rd_data) begin
            $display("%0t: read_data mismatch: expected %02h, actual %02h",
                     $time, want.rd_data, out_tdata[7:0]);
            errors++;
          end
          if (out_tuser[0] !== want.rd_ok) begin
            $display("%0t: read_valid mismatch: expected %b, actual %b",
                     $time, want.rd_ok, out_tuser[0]);
            errors++;
          end
          if (out_tuser[1] !== want.drop) begin
            $display("%0t: dropped mismatch: expected %b, actual %b",
                     $time, want.drop, out_tuser[1]);
            errors++;
          end
        end
      end
    end
  end

  task automatic queue_item(logic kind, logic [BYTE_W-1:0] chan, logic [BYTE_W-1:0] data);
    ring_req_t r;
    r.kind = kind;
    r.chan = chan;
    r.data = data;
    pending.push_back(r);
    items_issued++;
  endtask

  // Mixed random traffic; wide_pct of the tags span the whole byte
  task automatic queue_traffic(int count, int read_pct, int wide_pct);
    logic              kind;
    logic [BYTE_W-1:0] chan;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 99) < read_pct) ? REQ_READ : REQ_RX;
      chan = ($urandom_range(0, 99) < wide_pct) ? BYTE_W'($urandom_range(0, 255))
                                                : BYTE_W'($urandom_range(0, 3));
      queue_item(kind, chan, BYTE_W'($urandom()));
    end
  endtask

  // Wait until every issued beat was taken and every result came back
  task automatic wait_idle();
    while (items_accepted != items_issued || ring_expect.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_active(logic [ACT_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // only channel 0 active: empty read, extremes, unknown read channel, drops
    write_active(2'd0);
    queue_item(REQ_READ, 8'd0,   8'h00);
    queue_item(REQ_RX,   8'd0,   8'hff);
    queue_item(REQ_RX,   8'd0,   8'h00);
    queue_item(REQ_READ, 8'd0,   8'hff);
    queue_item(REQ_READ, 8'd255, 8'h00);
    queue_item(REQ_READ, 8'd0,   8'h00);
    queue_item(REQ_RX,   8'd1,   8'haa);
    queue_item(REQ_RX,   8'd255, 8'h55);

    // all channels active: tags just past the channel count are dropped
    write_active(2'd3);
    queue_item(REQ_RX,   8'd3,   8'ha5);
    queue_item(REQ_RX,   8'd4,   8'h11);
    queue_item(REQ_RX,   8'h80,  8'h22);
    queue_item(REQ_RX,   8'd2,   8'h5a);
    queue_item(REQ_READ, 8'd3,   8'h00);
    queue_item(REQ_READ, 8'd2,   8'h00);
    queue_item(REQ_READ, 8'd200, 8'h00);
    queue_item(REQ_READ, 8'd4,   8'h00);
    queue_item(REQ_RX,   8'd1,   8'h3c);
    queue_item(REQ_READ, 8'd1,   8'h00);
    queue_item(REQ_READ, 8'd1,   8'h00);

    queue_traffic(250, 45, 10);

    // drain channel 2, then fill it exactly: the ring must read as empty
    for (int i = 0; i < RING_DEPTH + 2; i++)
      queue_item(REQ_READ, 8'd2, BYTE_W'($urandom()));
    for (int i = 0; i < RING_DEPTH; i++)
      queue_item(REQ_RX, 8'd2, BYTE_W'($urandom()));
    queue_item(REQ_READ, 8'd2, 8'h00);
    queue_item(REQ_RX,   8'd2, 8'h69);
    queue_item(REQ_READ, 8'd2, 8'h00);

    write_active(2'd1);
    queue_traffic(250, 50, 15);
    write_active(2'd2);
    queue_traffic(250, 30, 5);
    write_active(2'd0);
    queue_traffic(250, 50, 20);
    write_active(2'd3);
    queue_traffic(250, 55, 10);

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // run limit
  initial begin
    #500000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/tcrr_pkg.sv
sv/tcrr_ram.sv
sv/tagged_channel_receive_rings.sv
sim/tagged_channel_receive_rings_test.sv
